// ===== hw/rtl/bup_pkg.sv =====
// shared widths, corner indexes, register map and stage payload types
package bup_pkg;

  localparam int PIX_W   = 8;
  localparam int OFS_W   = 6;
  localparam int GAP_W   = 6;
  localparam int WT_W    = GAP_W + 1;
  localparam int WW_W    = 2 * WT_W;
  localparam int PP_W    = WW_W + PIX_W + 1;
  localparam int SUM_W   = PP_W + 2;
  localparam int SQ_W    = 2 * GAP_W;
  localparam int DEN_W   = SQ_W + 1;
  localparam int NUM_W   = SUM_W;
  localparam int Q_W     = PIX_W;
  localparam int BPS     = 2;
  localparam int DIV_STG = Q_W / BPS;

  localparam int N_CRN   = 4;
  localparam int CRN_TL  = 0;
  localparam int CRN_TR  = 1;
  localparam int CRN_BL  = 2;
  localparam int CRN_BR  = 3;

  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_GAP = 1'b0;
  localparam logic [GAP_W-1:0]     GAP_RST = 6'd1;
  localparam logic [PIX_W-1:0]     PIX_MAX = 8'd255;

  typedef struct packed {
    logic [N_CRN-1:0][PP_W-1:0] pp;
    logic [SQ_W-1:0]            sq;
    logic                       zero_gap;
    logic [PIX_W-1:0]           top_left;
  } bup_prod_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             fixed;
    logic [PIX_W-1:0] fix_val;
  } bup_frac_t;

endpackage

// ===== hw/rtl/bilinear_upscale_pixel.sv =====
// bilinear upscale pixel: one output pixel from four corners and an offset
// throughput: one pixel per cycle while the receiver does not stall; a stall freezes only the stages that are full
// bubbles are squeezed out, so a full stage waits only behind another full stage
// reset clears the stage valid bits and sets gap to 1; data registers are not reset
module bilinear_upscale_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [bup_pkg::APB_AW-1:0]    paddr_i,
  input  logic [bup_pkg::APB_DW-1:0]    pwdata_i,
  output logic [bup_pkg::APB_DW-1:0]    prdata_o,
  output logic                          pready_o,
  // input channel
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [bup_pkg::PIX_W-1:0]     top_left_i,
  input  logic [bup_pkg::PIX_W-1:0]     top_right_i,
  input  logic [bup_pkg::PIX_W-1:0]     bottom_left_i,
  input  logic [bup_pkg::PIX_W-1:0]     bottom_right_i,
  input  logic [bup_pkg::OFS_W-1:0]     row_offset_i,
  input  logic [bup_pkg::OFS_W-1:0]     col_offset_i,
  // output channel
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [bup_pkg::PIX_W-1:0]     pixel_out_o
);
  import bup_pkg::*;

  logic [GAP_W-1:0] gap_q;
  logic             reg_wr, gap_sel;

  // register file: a single word, gap, at byte address 0
  assign pready_o = 1'b1;
  assign gap_sel  = (paddr_i[APB_AW-1:2] == REG_GAP);
  assign reg_wr   = psel_i & penable_i & pwrite_i & pready_o;
  assign prdata_o = gap_sel ? APB_DW'(gap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= GAP_RST;
    end else if (reg_wr && gap_sel) begin
      gap_q <= pwdata_i[GAP_W-1:0];
    end
  end

  // stage-to-stage channels; each stall is the downstream stage being full and held
  logic      wt_valid, wt_stall, ac_valid, ac_stall;
  bup_prod_t prod;
  bup_frac_t frac;

  // stages 1-2: signed weights (k-r)(k-c) etc., then weight times corner pixel
  bup_weight u_weight (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .top_left_i     (top_left_i),
    .top_right_i    (top_right_i),
    .bottom_left_i  (bottom_left_i),
    .bottom_right_i (bottom_right_i),
    .row_offset_i   (row_offset_i),
    .col_offset_i   (col_offset_i),
    .gap_i          (gap_q),
    .valid_o        (wt_valid),
    .stall_i        (wt_stall),
    .prod_o         (prod)
  );

  // stages 3-4: four-way sum, then 2n + k*k and the special-case flags
  // (zero gap passes top left through, a sum of zero or less gives 0)
  bup_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (wt_valid),
    .stall_o (wt_stall),
    .prod_i  (prod),
    .valid_o (ac_valid),
    .stall_i (ac_stall),
    .frac_o  (frac)
  );

  // stages 5-9: saturation at 255, then four stages of two quotient bits each;
  // the last stage register is the output register
  bup_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ac_valid),
    .stall_o (ac_stall),
    .frac_i  (frac),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .pixel_o (pixel_out_o)
  );

endmodule

// ===== hw/rtl/bup_weight.sv =====
// corner weights and weighted corner products, two register stages
module bup_weight (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic [bup_pkg::PIX_W-1:0] top_left_i,
  input  logic [bup_pkg::PIX_W-1:0] top_right_i,
  input  logic [bup_pkg::PIX_W-1:0] bottom_left_i,
  input  logic [bup_pkg::PIX_W-1:0] bottom_right_i,
  input  logic [bup_pkg::OFS_W-1:0] row_offset_i,
  input  logic [bup_pkg::OFS_W-1:0] col_offset_i,
  input  logic [bup_pkg::GAP_W-1:0] gap_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output bup_pkg::bup_prod_t      prod_o
);
  import bup_pkg::*;

  logic signed [WT_W-1:0] row_w, col_w, krow_w, kcol_w;
  logic signed [WW_W-1:0] ww_d [N_CRN];
  logic signed [WW_W-1:0] ww_q [N_CRN];
  logic [PIX_W-1:0]       pix_d [N_CRN];
  logic [PIX_W-1:0]       pix_q [N_CRN];
  logic [SQ_W-1:0]        sq_q;
  logic                   zero_q;
  logic                   v1_q, v2_q, stall1, stall2;
  logic signed [PP_W-1:0] pp_d [N_CRN];
  bup_prod_t              prod_d, prod_q;

  assign stall2  = v2_q & stall_i;
  assign stall1  = v1_q & stall2;
  assign stall_o = stall1;

  // stage 1: signed weights, may go negative for offsets beyond the gap
  always_comb begin
    row_w  = $signed({1'b0, row_offset_i});
    col_w  = $signed({1'b0, col_offset_i});
    krow_w = $signed({1'b0, gap_i}) - row_w;
    kcol_w = $signed({1'b0, gap_i}) - col_w;
    ww_d[CRN_TL] = krow_w * kcol_w;
    ww_d[CRN_TR] = krow_w * col_w;
    ww_d[CRN_BL] = row_w * kcol_w;
    ww_d[CRN_BR] = row_w * col_w;
    pix_d[CRN_TL] = top_left_i;
    pix_d[CRN_TR] = top_right_i;
    pix_d[CRN_BL] = bottom_left_i;
    pix_d[CRN_BR] = bottom_right_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (!stall1) v1_q <= valid_i;
      if (!stall2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall1 && valid_i) begin
      ww_q   <= ww_d;
      pix_q  <= pix_d;
      sq_q   <= gap_i * gap_i;
      zero_q <= (gap_i == '0);
    end
  end

  // stage 2: weight times pixel
  always_comb begin
    for (int i = 0; i < N_CRN; i++) begin
      pp_d[i]        = ww_q[i] * $signed({1'b0, pix_q[i]});
      prod_d.pp[i]   = pp_d[i];
    end
    prod_d.sq       = sq_q;
    prod_d.zero_gap = zero_q;
    prod_d.top_left = pix_q[CRN_TL];
  end

  always_ff @(posedge clk_i) begin
    if (!stall2 && v1_q) prod_q <= prod_d;
  end

  assign valid_o = v2_q;
  assign prod_o  = prod_q;

endmodule

// ===== hw/rtl/bup_accum.sv =====
// sum of corner products and rounding numerator, two register stages
module bup_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  bup_pkg::bup_prod_t prod_i,
  output logic               valid_o,
  input  logic               stall_i,
  output bup_pkg::bup_frac_t frac_o
);
  import bup_pkg::*;

  logic signed [SUM_W-1:0] sum_d, sum_q;
  logic [SQ_W-1:0]         sq_q;
  logic                    zero_q;
  logic [PIX_W-1:0]        tl_q;
  logic                    v3_q, v4_q, stall3, stall4, pos;
  bup_frac_t               frac_d, frac_q;

  assign stall4  = v4_q & stall_i;
  assign stall3  = v3_q & stall4;
  assign stall_o = stall3;

  assign sum_d = $signed(prod_i.pp[CRN_TL]) + $signed(prod_i.pp[CRN_TR])
               + $signed(prod_i.pp[CRN_BL]) + $signed(prod_i.pp[CRN_BR]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (!stall3) v3_q <= valid_i;
      if (!stall4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall3 && valid_i) begin
      sum_q  <= sum_d;
      sq_q   <= prod_i.sq;
      zero_q <= prod_i.zero_gap;
      tl_q   <= prod_i.top_left;
    end
  end

  // round half up: (2n + d) / 2d
  always_comb begin
    pos            = !sum_q[SUM_W-1] && (sum_q != '0);
    frac_d.num     = {sum_q[SUM_W-2:0], 1'b0} + NUM_W'(sq_q);
    frac_d.den     = {sq_q, 1'b0};
    frac_d.fixed   = zero_q || !pos;
    frac_d.fix_val = zero_q ? tl_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (!stall4 && v3_q) frac_q <= frac_d;
  end

  assign valid_o = v4_q;
  assign frac_o  = frac_q;

endmodule

// ===== hw/rtl/bup_div.sv =====
// saturation check and pipelined restoring divider, two quotient bits per stage
module bup_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  bup_pkg::bup_frac_t      frac_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [bup_pkg::PIX_W-1:0] pixel_o
);
  import bup_pkg::*;

  logic [DIV_STG:0]   v_q;
  logic [DIV_STG:0]   stl;
  logic [Q_W-1:0]     q_q   [DIV_STG+1];
  logic [NUM_W-1:0]   rem_q [DIV_STG];
  logic [DEN_W-1:0]   den_q [DIV_STG];
  logic [DIV_STG-1:0] skip_q;
  logic               ovf;

  // stage 0: quotient of 256 or more saturates
  assign ovf = frac_i.num >= (NUM_W'(frac_i.den) << Q_W);

  always_ff @(posedge clk_i) begin
    if (!stl[0] && valid_i) begin
      rem_q[0]  <= frac_i.num;
      den_q[0]  <= frac_i.den;
      skip_q[0] <= frac_i.fixed | ovf;
      q_q[0]    <= frac_i.fixed ? frac_i.fix_val : (ovf ? PIX_MAX : '0);
    end
  end

  assign stall_o = stl[0];

  for (genvar s = 0; s <= DIV_STG; s++) begin : g_ctl
    if (s == DIV_STG) begin : g_last
      assign stl[s] = v_q[s] & stall_i;
    end else begin : g_mid
      assign stl[s] = v_q[s] & stl[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (!stl[0]) v_q[0] <= valid_i;
      for (int s = 1; s <= DIV_STG; s++) begin
        if (!stl[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  for (genvar s = 1; s <= DIV_STG; s++) begin : g_stg
    localparam int BASE = Q_W - 1 - (s - 1) * BPS;
    logic [NUM_W-1:0] rem_t, trial;
    logic [Q_W-1:0]   q_t;

    always_comb begin
      rem_t = rem_q[s-1];
      q_t   = q_q[s-1];
      trial = '0;
      for (int j = 0; j < BPS; j++) begin
        trial = NUM_W'(den_q[s-1]) << (BASE - j);
        if (!skip_q[s-1] && rem_t >= trial) begin
          rem_t           = rem_t - trial;
          q_t[BASE - j]   = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (!stl[s] && v_q[s-1]) q_q[s] <= q_t;
    end

    if (s < DIV_STG) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (!stl[s] && v_q[s-1]) begin
          rem_q[s]  <= rem_t;
          den_q[s]  <= den_q[s-1];
          skip_q[s] <= skip_q[s-1];
        end
      end
    end
  end

  assign valid_o = v_q[DIV_STG];
  assign pixel_o = q_q[DIV_STG];

endmodule

// ===== dv/tb_top.sv =====
// testbench for bilinear_upscale_pixel: directed table and random pixels against a predictor
module tb_top;
  import bup_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RST_CYC     = 10;
  // settle time, longer than the latency of the pipeline
  localparam int SETTLE_CYC  = 16;
  // cycles without any transfer before the run is declared hung
  localparam int IDLE_LIMIT  = 3000;
  // long receiver hold-off, enough to fill every stage and back up the input
  localparam int HOLD_CYC    = 150;
  localparam int HOLD_ITEMS  = 60;
  localparam int PHASE_ITEMS = 100;
  localparam int N_PHASES    = 9;

  localparam logic [REG_IDX_W-1:0] REG_SPARE  = 1'b1;
  localparam logic [APB_AW-1:0]    ADDR_GAP   = {REG_GAP, 2'b00};
  localparam logic [APB_AW-1:0]    ADDR_SPARE = {REG_SPARE, 2'b00};

  // one input transfer: four corners and the offset inside the block
  typedef struct packed {
    logic [PIX_W-1:0] tl;
    logic [PIX_W-1:0] tr;
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] br;
    logic [OFS_W-1:0] row;
    logic [OFS_W-1:0] col;
  } corner_req_t;

  // directed row: gap register value, corners, offsets, and a typed-in pixel when known
  typedef struct packed {
    logic [APB_DW-1:0] gap_wr;
    logic [PIX_W-1:0]  tl;
    logic [PIX_W-1:0]  tr;
    logic [PIX_W-1:0]  bl;
    logic [PIX_W-1:0]  br;
    logic [OFS_W-1:0]  row;
    logic [OFS_W-1:0]  col;
    logic              known;
    logic [PIX_W-1:0]  pix;
  } dir_row_t;

  localparam int N_DIR = 22;

  // gap value 64 lands as gap zero after the 6-bit mask
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    // reset gap of one: each corner alone, then an offset past the block
    '{32'd1,  8'd0,   8'd0,   8'd0,   8'd0,   6'd0,  6'd0,  1'b1, 8'd0},
    '{32'd1,  8'd255, 8'd0,   8'd0,   8'd0,   6'd0,  6'd0,  1'b1, 8'd255},
    '{32'd1,  8'd0,   8'd200, 8'd0,   8'd0,   6'd0,  6'd1,  1'b1, 8'd200},
    '{32'd1,  8'd0,   8'd0,   8'd77,  8'd0,   6'd1,  6'd0,  1'b1, 8'd77},
    '{32'd1,  8'd0,   8'd0,   8'd0,   8'd255, 6'd1,  6'd1,  1'b1, 8'd255},
    '{32'd1,  8'd10,  8'd20,  8'd30,  8'd40,  6'd2,  6'd3,  1'b0, 8'd0},
    // widest block: flat corners give the corner value anywhere; at a corner offset the output is that corner
    '{32'd63, 8'd255, 8'd255, 8'd255, 8'd255, 6'd31, 6'd40, 1'b1, 8'd255},
    '{32'd63, 8'd128, 8'd128, 8'd128, 8'd128, 6'd63, 6'd63, 1'b1, 8'd128},
    '{32'd63, 8'd255, 8'd0,   8'd0,   8'd0,   6'd0,  6'd0,  1'b1, 8'd255},
    '{32'd63, 8'd0,   8'd0,   8'd0,   8'd255, 6'd63, 6'd63, 1'b1, 8'd255},
    '{32'd63, 8'd17,  8'd250, 8'd3,   8'd99,  6'd21, 6'd42, 1'b0, 8'd0},
    '{32'd63, 8'd0,   8'd255, 8'd255, 8'd0,   6'd0,  6'd63, 1'b1, 8'd255},
    // offset past the block: negative sum floors at zero, large sum clamps
    '{32'd2,  8'd255, 8'd0,   8'd0,   8'd0,   6'd63, 6'd0,  1'b1, 8'd0},
    '{32'd2,  8'd0,   8'd0,   8'd255, 8'd0,   6'd63, 6'd0,  1'b1, 8'd255},
    // a quarter rounds down, a half rounds up
    '{32'd2,  8'd1,   8'd0,   8'd0,   8'd0,   6'd1,  6'd1,  1'b1, 8'd0},
    '{32'd2,  8'd2,   8'd0,   8'd0,   8'd0,   6'd1,  6'd1,  1'b1, 8'd1},
    '{32'd2,  8'd5,   8'd90,  8'd200, 8'd33,  6'd1,  6'd2,  1'b0, 8'd0},
    // zero gap: top-left passes straight through; then gap 5 with offsets inside and past the block
    '{32'd64, 8'd99,  8'd200, 8'd200, 8'd200, 6'd5,  6'd7,  1'b1, 8'd99},
    '{32'd64, 8'd255, 8'd0,   8'd0,   8'd0,   6'd63, 6'd63, 1'b1, 8'd255},
    '{32'd64, 8'd0,   8'd255, 8'd255, 8'd255, 6'd0,  6'd0,  1'b1, 8'd0},
    '{32'd5,  8'd12,  8'd34,  8'd56,  8'd78,  6'd3,  6'd2,  1'b0, 8'd0},
    '{32'd5,  8'd200, 8'd100, 8'd50,  8'd25,  6'd63, 6'd63, 1'b0, 8'd0}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel_i;
  logic                 penable_i;
  logic                 pwrite_i;
  logic [APB_AW-1:0]    paddr_i;
  logic [APB_DW-1:0]    pwdata_i;
  logic [APB_DW-1:0]    prdata_o;
  logic                 pready_o;
  logic                 valid_i;
  logic                 stall_o;
  logic [PIX_W-1:0]     top_left_i;
  logic [PIX_W-1:0]     top_right_i;
  logic [PIX_W-1:0]     bottom_left_i;
  logic [PIX_W-1:0]     bottom_right_i;
  logic [OFS_W-1:0]     row_offset_i;
  logic [OFS_W-1:0]     col_offset_i;
  logic                 valid_o;
  logic                 stall_i;
  logic [PIX_W-1:0]     pixel_out_o;

  // predictor copy of the gap register
  logic [GAP_W-1:0]     gap_shadow;
  // pixels still owed by the block, oldest first
  logic [PIX_W-1:0]     pixel_exp_q[$];
  logic [PIX_W-1:0]     pixel_want;
  int                   mismatches;
  int                   idle_pct;
  int                   stall_pct;
  int                   hold_left;
  int                   quiet_cyc;

  bilinear_upscale_pixel i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel_i),
    .penable_i      (penable_i),
    .pwrite_i       (pwrite_i),
    .paddr_i        (paddr_i),
    .pwdata_i       (pwdata_i),
    .prdata_o       (prdata_o),
    .pready_o       (pready_o),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .top_left_i     (top_left_i),
    .top_right_i    (top_right_i),
    .bottom_left_i  (bottom_left_i),
    .bottom_right_i (bottom_right_i),
    .row_offset_i   (row_offset_i),
    .col_offset_i   (col_offset_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .pixel_out_o    (pixel_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // expected pixel: top left for a zero gap, else weighted corner sum over k*k, rounded half up, clamped
  function automatic logic [PIX_W-1:0] bilerp_pixel(input corner_req_t req,
                                                    input logic [GAP_W-1:0] k_in);
    longint k, r, c, n, d, q;
    k = k_in;
    r = req.row;
    c = req.col;
    if (k == 0) return req.tl;
    // signed weights, so offsets past the block extrapolate
    n = (k - r) * (k - c) * longint'(req.tl)
      + (k - r) * c * longint'(req.tr)
      + r * (k - c) * longint'(req.bl)
      + r * c * longint'(req.br);
    if (n <= 0) return '0;
    d = k * k;
    q = (2 * n + d) / (2 * d);
    if (q > longint'(PIX_MAX)) q = PIX_MAX;
    return q[PIX_W-1:0];
  endfunction

  // pixel values lean on the extremes now and then
  function automatic logic [PIX_W-1:0] random_pix();
    case ($urandom_range(9))
      0:       return '0;
      1:       return PIX_MAX;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // offsets mostly inside the block, sometimes anywhere in the field, and always anywhere when the gap is zero
  function automatic corner_req_t random_req(input logic [GAP_W-1:0] k);
    corner_req_t req;
    req.tl = random_pix();
    req.tr = random_pix();
    req.bl = random_pix();
    req.br = random_pix();
    if (k == 0 || $urandom_range(99) < 15) begin
      req.row = OFS_W'($urandom_range(63));
      req.col = OFS_W'($urandom_range(63));
    end else begin
      req.row = OFS_W'($urandom_range(k));
      req.col = OFS_W'($urandom_range(k));
    end
    return req;
  endfunction

  // one input transfer; the expected pixel is queued at the accepting edge
  task automatic offer_pixel(input corner_req_t req, input logic typed,
                             input logic [PIX_W-1:0] typed_pix);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i        <= 1'b1;
    top_left_i     <= req.tl;
    top_right_i    <= req.tr;
    bottom_left_i  <= req.bl;
    bottom_right_i <= req.br;
    row_offset_i   <= req.row;
    col_offset_i   <= req.col;
    do @(posedge clk_i); while (stall_o !== 1'b0);
    pixel_exp_q.push_back(typed ? typed_pix : bilerp_pixel(req, gap_shadow));
  endtask

  // drop valid and let every owed pixel come out
  task automatic wait_results();
    @(negedge clk_i);
    valid_i <= 1'b0;
    while (pixel_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // setup phase then access phase; read data is taken at the access edge
  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= wr;
    paddr_i   <= addr;
    pwdata_i  <= wdata;
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (pready_o !== 1'b1);
    rdata = prdata_o;
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
  endtask

  task automatic readback_gap();
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, ADDR_GAP, '0, rd);
    if (rd !== APB_DW'(gap_shadow)) begin
      $error("gap readback mismatch: expected %0d, actual %0d", gap_shadow, rd);
      mismatches++;
    end
  endtask

  // only while idle: every pixel in flight has already come out
  task automatic write_gap(input logic [APB_DW-1:0] val);
    logic [APB_DW-1:0] rd;
    wait_results();
    apb_access(1'b1, ADDR_GAP, val, rd);
    gap_shadow = val[GAP_W-1:0];
    readback_gap();
  endtask

  // receiver: random stalls, or a long hold-off counted down here
  initial begin : receiver
    stall_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        stall_i <= 1'b1;
        hold_left--;
      end else begin
        stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // output side: compare each pixel transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1 && stall_i === 1'b0) begin
      if (pixel_exp_q.size() == 0) begin
        $error("pixel_out: unexpected transfer, actual %0d", pixel_out_o);
        mismatches++;
      end else begin
        pixel_want = pixel_exp_q.pop_front();
        if (pixel_out_o !== pixel_want) begin
          $error("pixel_out mismatch: expected %0d, actual %0d", pixel_want, pixel_out_o);
          mismatches++;
        end
      end
    end
  end

  // hang detection: cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      quiet_cyc = 0;
    end else begin
      quiet_cyc++;
      if (quiet_cyc >= IDLE_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    corner_req_t       req;
    logic [APB_DW-1:0] last_wr;
    logic [APB_DW-1:0] wr_val;
    logic [APB_DW-1:0] rd;
    logic [GAP_W-1:0]  k;

    // every input known from time zero
    rst_ni         = 1'b0;
    psel_i         = 1'b0;
    penable_i      = 1'b0;
    pwrite_i       = 1'b0;
    paddr_i        = '0;
    pwdata_i       = '0;
    valid_i        = 1'b0;
    top_left_i     = '0;
    top_right_i    = '0;
    bottom_left_i  = '0;
    bottom_right_i = '0;
    row_offset_i   = '0;
    col_offset_i   = '0;
    mismatches     = 0;
    quiet_cyc      = 0;
    hold_left      = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    gap_shadow     = GAP_RST;

    repeat (RST_CYC) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table; first rows run on the reset gap
    last_wr = APB_DW'(GAP_RST);
    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_TAB[i].gap_wr != last_wr) begin
        write_gap(DIR_TAB[i].gap_wr);
        last_wr = DIR_TAB[i].gap_wr;
      end
      req = '{DIR_TAB[i].tl, DIR_TAB[i].tr, DIR_TAB[i].bl, DIR_TAB[i].br,
              DIR_TAB[i].row, DIR_TAB[i].col};
      offer_pixel(req, DIR_TAB[i].known, DIR_TAB[i].pix);
    end

    // write to an unmapped register must leave gap alone
    wait_results();
    apb_access(1'b1, ADDR_SPARE, 32'h0000_0015, rd);
    readback_gap();
    repeat (5) offer_pixel(random_req(gap_shadow), 1'b0, '0);

    // back-pressure: receiver holds off while the sender keeps offering
    wait_results();
    hold_left = HOLD_CYC;
    repeat (HOLD_ITEMS) offer_pixel(random_req(gap_shadow), 1'b0, '0);

    // random phases across gap settings and idling patterns
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       k = GAP_W'(1);
        1:       k = GAP_W'(63);
        2:       k = '0;
        3:       k = GAP_W'(2);
        8:       k = GAP_W'(63);
        default: k = GAP_W'($urandom_range(63, 1));
      endcase
      // random upper bits must be dropped by the register
      wr_val = $urandom;
      wr_val[GAP_W-1:0] = k;
      write_gap(wr_val);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender pause until the pipe is empty
        if (n == PHASE_ITEMS / 2 && p % 3 == 0) wait_results();
        offer_pixel(random_req(gap_shadow), 1'b0, '0);
      end
    end

    wait_results();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bup_pkg.sv
hw/rtl/bup_weight.sv
hw/rtl/bup_accum.sv
hw/rtl/bup_div.sv
hw/rtl/bilinear_upscale_pixel.sv
dv/tb_top.sv
